// ===== rtl/kmsd_pkg.sv =====
// kmsd_pkg: shared types and constants of the debounced key matrix scanner
// no dependencies; imported by every module under rtl

package kmsd_pkg;

  localparam int SAMP_W    = 7;   // sample index, pressed count, min and max registers
  localparam int CONF_W    = 4;   // confidence in tenths
  localparam int PROD_W    = 11;  // wide enough for 10*127 and 15*127
  localparam int PIN_W     = 4;   // sampled column pins and driven row lines
  localparam int KEY_MAP_W = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [SAMP_W-1:0] MIN_SAMPLES_RST = 7'd3;
  localparam logic [SAMP_W-1:0] MAX_SAMPLES_RST = 7'd100;
  localparam logic [CONF_W-1:0] CONF_RST        = 4'd7;

  typedef enum logic [1:0] {
    REG_MIN_SAMPLES = 2'd0,
    REG_MAX_SAMPLES = 2'd1,
    REG_CONFIDENCE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERD_NONE     = 2'd0,
    VERD_RELEASED = 2'd1,
    VERD_PRESSED  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [SAMP_W-1:0] min_samples;
    logic [SAMP_W-1:0] max_samples;
    logic [CONF_W-1:0] confidence_tenths;
  } cfg_t;

endpackage

// ===== rtl/kmsd_cfg.sv =====
// kmsd_cfg: apb-style register file holding the debounce thresholds
// depends on kmsd_pkg

module kmsd_cfg
  import kmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SAMP_W-1:0] min_samples_r;
  logic [SAMP_W-1:0] max_samples_r;
  logic [CONF_W-1:0] conf_r;
  logic              wr_en;
  reg_idx_t          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_samples_r <= MIN_SAMPLES_RST;
      max_samples_r <= MAX_SAMPLES_RST;
      conf_r        <= CONF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_SAMPLES: min_samples_r <= pwdata[SAMP_W-1:0];
        REG_MAX_SAMPLES: max_samples_r <= pwdata[SAMP_W-1:0];
        REG_CONFIDENCE:  conf_r        <= pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_SAMPLES: prdata = DATA_W'(min_samples_r);
      REG_MAX_SAMPLES: prdata = DATA_W'(max_samples_r);
      REG_CONFIDENCE:  prdata = DATA_W'(conf_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.min_samples       = min_samples_r;
  assign cfg.max_samples       = max_samples_r;
  assign cfg.confidence_tenths = conf_r;

endmodule

// ===== rtl/kmsd_debounce.sv =====
// kmsd_debounce: one debounce step for the key under scan, pure logic
// depends on kmsd_pkg

module kmsd_debounce
  import kmsd_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [SAMP_W-1:0] sample_index,
  input  logic [SAMP_W-1:0] pressed_count,
  input  logic              pressed,
  output verdict_t          verdict,
  output logic [SAMP_W-1:0] count_sum
);

  logic [PROD_W-1:0] need;
  logic [PROD_W-1:0] ten_h;
  logic [PROD_W-1:0] ten_rel;
  logic [SAMP_W-1:0] rel_cnt;
  logic              early;
  logic              press_ok;
  logic              rel_ok;
  logic              forced;
  logic              majority;

  // count includes this sample; it never exceeds sample_index + 1
  assign count_sum = pressed_count + SAMP_W'(pressed);
  assign rel_cnt   = sample_index - count_sum;

  assign need    = PROD_W'(cfg.confidence_tenths) * PROD_W'(sample_index);
  assign ten_h   = PROD_W'(count_sum) * PROD_W'(10);
  assign ten_rel = PROD_W'(rel_cnt) * PROD_W'(10);

  assign early    = sample_index > cfg.min_samples;
  assign press_ok = ten_h >= need;
  // released count would be negative when every sample so far was pressed
  assign rel_ok   = (count_sum <= sample_index) && (ten_rel >= need);
  assign forced   = ({1'b0, sample_index} + 8'd1) >= {1'b0, cfg.max_samples};
  assign majority = {count_sum, 1'b0} > {1'b0, sample_index};

  always_comb begin
    if (early && press_ok) begin
      verdict = VERD_PRESSED;
    end else if (early && rel_ok) begin
      verdict = VERD_RELEASED;
    end else if (forced) begin
      verdict = majority ? VERD_PRESSED : VERD_RELEASED;
    end else begin
      verdict = VERD_NONE;
    end
  end

endmodule

// ===== rtl/keypad_matrix_scan_debounce.sv =====
// keypad_matrix_scan_debounce: top level, scan sequencing and result register
// depends on kmsd_pkg, kmsd_cfg, kmsd_debounce
//
// Each input beat is one scan tick carrying the sampled column pins; each
// accepted beat yields exactly one result beat with the row drive, busy and
// done flags and, on completion, the key map or the single-key bit. A start
// beat only selects the row and column; the columns are sampled from the
// next beat on, one key at a time, until that key's debounce verdict. The
// block takes one beat per clock cycle unless the output stalls: the
// state update is a single debounce step (three small products and a few
// compares) between the scan state registers and the result register; a
// new beat is accepted whenever the result register is empty or being taken.

module keypad_matrix_scan_debounce
  import kmsd_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // scan tick channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_start_req,
  input  logic                 in_single_key,
  input  logic [1:0]           in_key_row,
  input  logic [1:0]           in_key_col,
  input  logic [PIN_W-1:0]     in_column_levels,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIN_W-1:0]     out_row_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [KEY_MAP_W-1:0] out_key_map,
  output logic                 out_key_pressed,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int NKEYS = ROWS * COLS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int POS_W = $clog2(NKEYS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  cfg_t cfg;

  logic              active_r,   active_nxt;
  logic              single_r,   single_nxt;
  logic [ROW_W-1:0]  row_r,      row_nxt;
  logic [COL_W-1:0]  col_r,      col_nxt;
  logic [SAMP_W-1:0] samp_r,     samp_nxt;
  logic [SAMP_W-1:0] cnt_r,      cnt_nxt;
  logic [NKEYS-1:0]  map_r,      map_nxt;

  logic                 out_valid_r;
  logic [PIN_W-1:0]     row_drive_r;
  logic                 busy_r;
  logic                 done_r;
  logic [KEY_MAP_W-1:0] key_map_r;
  logic                 key_pressed_r;

  logic                 accept;
  logic                 level_high;
  logic [PIN_W-1:0]     levels_sh;
  logic                 col_in_pins;
  logic                 row_in_pins;
  logic [POS_W-1:0]     pos;
  logic [NKEYS-1:0]     map_bit;
  verdict_t             verdict;
  logic [SAMP_W-1:0]    count_sum;
  logic                 pressed_bit;
  logic                 done;
  logic [KEY_MAP_W-1:0] map_out;
  logic                 bit_out;
  logic [PIN_W-1:0]     drive;

  kmsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // columns past the sampled pins read as released
  assign levels_sh   = in_column_levels >> col_r;
  assign col_in_pins = 32'(col_r) < PIN_W;
  assign level_high  = col_in_pins ? levels_sh[0] : 1'b1;

  kmsd_debounce u_debounce (
    .cfg           (cfg),
    .sample_index  (samp_r),
    .pressed_count (cnt_r),
    .pressed       (~level_high),
    .verdict       (verdict),
    .count_sum     (count_sum)
  );

  assign pos         = POS_W'(row_r) * POS_W'(COLS) + POS_W'(col_r);
  assign pressed_bit = (verdict == VERD_PRESSED);
  assign map_bit     = NKEYS'(pressed_bit) << pos;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    active_nxt = active_r;
    single_nxt = single_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    samp_nxt   = samp_r;
    cnt_nxt    = cnt_r;
    map_nxt    = map_r;
    done       = 1'b0;
    map_out    = '0;
    bit_out    = 1'b0;
    if (!active_r) begin
      if (in_start_req) begin
        active_nxt = 1'b1;
        single_nxt = in_single_key;
        if (in_single_key) begin
          // query beyond the matrix saturates to the last row or column
          row_nxt = (32'(in_key_row) >= ROWS) ? ROW_LAST : ROW_W'(in_key_row);
          col_nxt = (32'(in_key_col) >= COLS) ? COL_LAST : COL_W'(in_key_col);
        end else begin
          row_nxt = '0;
          col_nxt = '0;
        end
        samp_nxt = '0;
        cnt_nxt  = '0;
        map_nxt  = '0;
      end
    end else if (verdict == VERD_NONE) begin
      samp_nxt = samp_r + SAMP_W'(1);
      cnt_nxt  = count_sum;
    end else begin
      samp_nxt = '0;
      cnt_nxt  = '0;
      if (single_r) begin
        done    = 1'b1;
        bit_out = pressed_bit;
      end else begin
        map_nxt = map_r | map_bit;
        if (col_r == COL_LAST) begin
          col_nxt = '0;
          if (row_r == ROW_LAST) begin
            row_nxt = '0;
            done    = 1'b1;
            map_out = KEY_MAP_W'(map_nxt);
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  // rows past the driven lines leave all lines high
  assign row_in_pins = 32'(row_nxt) < PIN_W;
  assign drive = (active_nxt && row_in_pins) ? ~(PIN_W'(1) << row_nxt) : '1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      single_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      samp_r   <= '0;
      cnt_r    <= '0;
      map_r    <= '0;
    end else if (accept) begin
      active_r <= active_nxt;
      single_r <= single_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      samp_r   <= samp_nxt;
      cnt_r    <= cnt_nxt;
      map_r    <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_drive_r   <= drive;
      busy_r        <= active_nxt;
      done_r        <= done;
      key_map_r     <= map_out;
      key_pressed_r <= bit_out;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_drive   = row_drive_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_key_map     = key_map_r;
  assign out_key_pressed = key_pressed_r;

`ifndef SYNTHESIS
  // idle scan state keeps its counters cleared
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (samp_r == '0) && (cnt_r == '0))
    else $error("counters not cleared while idle");

  // pressed samples never outnumber samples taken
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= samp_r)
    else $error("pressed count exceeds sample index");

  // a completing beat always reports the block as no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !busy_r)
    else $error("done beat reports busy");

  // the map and query bit are only shown on a completing beat
  a_result_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((key_map_r != '0) || key_pressed_r) |-> done_r)
    else $error("result bits outside a done beat");

  // accepting a beat while busy with no verdict advances the sample index
  a_busy_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept && active_r && (verdict == VERD_NONE) |=> samp_r == $past(samp_r) + SAMP_W'(1))
    else $error("sample index failed to advance");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// testbench: self-checking bench for keypad_matrix_scan_debounce
// depends on kmsd_pkg and the rtl; drives scan ticks and the register port, checks every result

module testbench
  import kmsd_pkg::*;
();

  localparam int KEY_ROWS    = 4;
  localparam int KEY_COLS    = 4;
  localparam int STALL_PCT   = 19;
  localparam int TICK_TARGET = 850;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic             start_req;
    logic             single_key;
    logic [1:0]       key_row;
    logic [1:0]       key_col;
    logic [PIN_W-1:0] column_levels;
  } scan_tick_t;

  typedef struct packed {
    logic [PIN_W-1:0]     row_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [KEY_MAP_W-1:0] key_map;
    logic                 key_pressed;
  } scan_report_t;

  class keypad_scoreboard;
    logic [SAMP_W-1:0]    min_samples_q;
    logic [SAMP_W-1:0]    max_samples_q;
    logic [CONF_W-1:0]    conf_q;
    logic                 scanning;
    logic                 single_mode;
    int                   row_idx;
    int                   col_idx;
    logic [SAMP_W-1:0]    sample_idx;
    logic [SAMP_W-1:0]    hit_count;
    logic [KEY_MAP_W-1:0] map_acc;
    scan_report_t         reports_due[$];
    int                   fail_count;
    int                   result_count;

    function new();
      min_samples_q = MIN_SAMPLES_RST;
      max_samples_q = MAX_SAMPLES_RST;
      conf_q        = CONF_RST;
      scanning      = 1'b0;
      single_mode   = 1'b0;
      row_idx       = 0;
      col_idx       = 0;
      sample_idx    = '0;
      hit_count     = '0;
      map_acc       = '0;
      fail_count    = 0;
      result_count  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_MIN_SAMPLES: min_samples_q = value[SAMP_W-1:0];
        REG_MAX_SAMPLES: max_samples_q = value[SAMP_W-1:0];
        REG_CONFIDENCE:  conf_q = value[CONF_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_MIN_SAMPLES: return DATA_W'(min_samples_q);
        REG_MAX_SAMPLES: return DATA_W'(max_samples_q);
        default:         return DATA_W'(conf_q);
      endcase
    endfunction

    function void report_mismatch(string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // one sample of the key under test; i counts from 0, h includes this sample
    function verdict_t debounce_step(logic pressed);
      int i;
      int h;
      int need;
      int lo;
      if (pressed) hit_count++;
      i    = int'(sample_idx);
      h    = int'(hit_count);
      lo   = int'(min_samples_q);
      need = int'(conf_q) * i;
      if (i > lo && 10 * h >= need) return VERD_PRESSED;
      if (i > lo && 10 * (i - h) >= need) return VERD_RELEASED;
      if (i + 1 >= int'(max_samples_q)) return (2 * h > i) ? VERD_PRESSED : VERD_RELEASED;
      sample_idx++;
      return VERD_NONE;
    endfunction

    function void note_tick(scan_tick_t t);
      scan_report_t r;
      verdict_t     v;
      r = '0;
      if (!scanning) begin
        // the start beat only selects the row and column, no sample taken
        if (t.start_req) begin
          scanning    = 1'b1;
          single_mode = t.single_key;
          if (single_mode) begin
            row_idx = (int'(t.key_row) >= KEY_ROWS) ? KEY_ROWS - 1 : int'(t.key_row);
            col_idx = (int'(t.key_col) >= KEY_COLS) ? KEY_COLS - 1 : int'(t.key_col);
          end else begin
            row_idx = 0;
            col_idx = 0;
          end
          sample_idx = '0;
          hit_count  = '0;
          map_acc    = '0;
        end
      end else begin
        v = debounce_step(!t.column_levels[col_idx]);
        if (v != VERD_NONE) begin
          sample_idx = '0;
          hit_count  = '0;
          if (single_mode) begin
            r.done_res    = 1'b1;
            r.key_pressed = (v == VERD_PRESSED);
          end else begin
            if (v == VERD_PRESSED) map_acc[row_idx * KEY_COLS + col_idx] = 1'b1;
            col_idx++;
            if (col_idx >= KEY_COLS) begin
              col_idx = 0;
              row_idx++;
              if (row_idx >= KEY_ROWS) begin
                row_idx    = 0;
                r.done_res = 1'b1;
                r.key_map  = map_acc;
              end
            end
          end
          if (r.done_res) scanning = 1'b0;
        end
      end
      r.row_drive = scanning ? (4'hF ^ (4'b0001 << row_idx)) : 4'hF;
      r.busy_res  = scanning;
      reports_due.push_back(r);
    endfunction

    function void check_result(scan_report_t got);
      scan_report_t want;
      result_count++;
      if (reports_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        return;
      end
      want = reports_due.pop_front();
      if (got.row_drive !== want.row_drive)
        report_mismatch($sformatf("result %0d row_drive %h, expected %h",
                                  result_count, got.row_drive, want.row_drive));
      if (got.busy_res !== want.busy_res)
        report_mismatch($sformatf("result %0d busy_res %b, expected %b",
                                  result_count, got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("result %0d done_res %b, expected %b",
                                  result_count, got.done_res, want.done_res));
      if (got.key_map !== want.key_map)
        report_mismatch($sformatf("result %0d key_map %h, expected %h",
                                  result_count, got.key_map, want.key_map));
      if (got.key_pressed !== want.key_pressed)
        report_mismatch($sformatf("result %0d key_pressed %b, expected %b",
                                  result_count, got.key_pressed, want.key_pressed));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_req = 1'b0;
  logic                 in_single_key = 1'b0;
  logic [1:0]           in_key_row = 2'd0;
  logic [1:0]           in_key_col = 2'd0;
  logic [PIN_W-1:0]     in_column_levels = '1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIN_W-1:0]     out_row_drive;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [KEY_MAP_W-1:0] out_key_map;
  logic                 out_key_pressed;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  logic             idle_en = 1'b1;
  int               ticks_sent = 0;
  int               quiet_cycles = 0;
  keypad_scoreboard sb;

  keypad_matrix_scan_debounce #(
    .ROWS(KEY_ROWS),
    .COLS(KEY_COLS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_req    (in_start_req),
    .in_single_key   (in_single_key),
    .in_key_row      (in_key_row),
    .in_key_col      (in_key_col),
    .in_column_levels(in_column_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_drive   (out_row_drive),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_key_map     (out_key_map),
    .out_key_pressed (out_key_pressed),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_row_drive, out_busy_res, out_done_res, out_key_map, out_key_pressed});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_tick(scan_tick_t t);
    if (idle_en) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_start_req     <= t.start_req;
    in_single_key    <= t.single_key;
    in_key_row       <= t.key_row;
    in_key_col       <= t.key_col;
    in_column_levels <= t.column_levels;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // beats with start low while idle, every other field random
  task automatic send_idle_ticks(int count);
    scan_tick_t t;
    repeat (count) begin
      t.start_req     = 1'b0;
      t.single_key    = 1'($urandom_range(1));
      t.key_row       = 2'($urandom_range(3));
      t.key_col       = 2'($urandom_range(3));
      t.column_levels = PIN_W'($urandom_range(15));
      send_tick(t);
    end
  endtask

  // one scan or query; pins follow a target map with random bounce on top
  task automatic run_scan(logic single, int row, int col, logic [KEY_MAP_W-1:0] target,
                          int bounce_pct);
    scan_tick_t t;
    logic       pressed;
    t.start_req     = 1'b1;
    t.single_key    = single;
    t.key_row       = row[1:0];
    t.key_col       = col[1:0];
    t.column_levels = PIN_W'($urandom_range(15));
    send_tick(t);
    while (sb.scanning) begin
      // start and key fields are ignored while busy, so they stay random
      t.start_req  = 1'($urandom_range(1));
      t.single_key = 1'($urandom_range(1));
      t.key_row    = 2'($urandom_range(3));
      t.key_col    = 2'($urandom_range(3));
      for (int j = 0; j < PIN_W; j++) begin
        pressed = target[sb.row_idx * KEY_COLS + j] ^ ($urandom_range(99) < bounce_pct);
        t.column_levels[j] = !pressed;
      end
      send_tick(t);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write, then read back on the same select
  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] want;
    mask    = (idx == REG_CONFIDENCE) ? DATA_W'((1 << CONF_W) - 1) : DATA_W'((1 << SAMP_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = sb.reg_value(idx);
    if ((prdata & mask) !== want)
      sb.report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                   idx.name(), prdata & mask, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int   mn;
    int   mx;
    int   cf;
    int   n_scans;
    int   bounce;
    logic long_keys;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle beats, corner keys held and released, forced first-sample scan
    send_idle_ticks(2);
    run_scan(1'b1, 0, 0, 16'hFFFF, 0);
    run_scan(1'b1, 3, 3, 16'h0000, 0);
    drain();
    cfg_write(REG_MAX_SAMPLES, 1);
    cfg_write(REG_MIN_SAMPLES, 0);
    run_scan(1'b0, 0, 0, 16'hA5C3, 0);
    drain();

    for (int phase = 0; ticks_sent < TICK_TARGET; phase++) begin
      case (phase)
        0:       begin mn = 0;   mx = 2;   cf = 5;  end
        1:       begin mn = 125; mx = 127; cf = 10; end
        2:       begin mn = 127; mx = 0;   cf = 15; end
        3:       begin mn = 5;   mx = 3;   cf = 0;  end
        4:       begin mn = 3;   mx = 100; cf = 7;  end
        5:       begin mn = 0;   mx = 127; cf = 10; end
        default: begin
          mn = $urandom_range(6);
          mx = ($urandom_range(11) == 0) ? $urandom_range(127, 11) : $urandom_range(10, 2);
          cf = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(10, 5);
        end
      endcase
      cfg_write(REG_MIN_SAMPLES, mn);
      cfg_write(REG_MAX_SAMPLES, mx);
      cfg_write(REG_CONFIDENCE, cf);
      idle_en <= (phase != 3 && phase != 8);
      // slow settings get single queries only, to keep full scans short
      long_keys = (mx > 16);
      n_scans   = long_keys ? $urandom_range(2, 1) : $urandom_range(5, 2);
      repeat (n_scans) begin
        if ($urandom_range(4) == 0) send_idle_ticks($urandom_range(2, 1));
        case ($urandom_range(3))
          0:       bounce = 0;
          1:       bounce = 5;
          2:       bounce = 20;
          default: bounce = 45;
        endcase
        run_scan(long_keys || ($urandom_range(99) < 40), $urandom_range(3),
                 $urandom_range(3), KEY_MAP_W'($urandom_range(16'hFFFF)), bounce);
      end
      drain();
    end

    if (sb.fail_count == 0 && sb.reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
